// ===== hdl/bdl_pkg.sv =====
`default_nettype none

package bdl_pkg;

  localparam int BUTTON_COUNT = 6;
  localparam int IDX_W        = $clog2(BUTTON_COUNT + 1);
  localparam int CNT_W        = 8;
  localparam int FIELD_W      = 3;
  localparam int CFG_W        = 8;

  localparam logic [CNT_W-1:0] RESET_TICKS = CNT_W'(60);
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LOCKOUT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] new_press;
    logic [FIELD_W-1:0] chord_button;
    logic [FIELD_W-1:0] held_button;
    logic               busy;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/bdl_cfg.sv =====
`default_nettype none

module bdl_cfg (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire                       cfg_index,
  input  wire [bdl_pkg::CFG_W-1:0]  cfg_data,
  output bdl_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= bdl_pkg::RESET_TICKS;
      cfg.lockout_ticks  <= bdl_pkg::RESET_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        bdl_pkg::CFG_DEBOUNCE: cfg.debounce_ticks <= cfg_data[bdl_pkg::CNT_W-1:0];
        bdl_pkg::CFG_LOCKOUT:  cfg.lockout_ticks  <= cfg_data[bdl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bdl_core.sv =====
`default_nettype none

module bdl_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              advance,
  input  wire [bdl_pkg::BUTTON_COUNT-1:0]  levels,
  input  wire                              game_active,
  input  wire bdl_pkg::cfg_t               cfg,
  output bdl_pkg::res_t                    res
);

  logic [bdl_pkg::IDX_W-1:0] registered_index;
  logic [bdl_pkg::CNT_W-1:0] tick_count;
  logic                      lockout_active;

  logic [bdl_pkg::IDX_W-1:0] registered_index_next;
  logic [bdl_pkg::CNT_W-1:0] tick_count_next;
  logic                      lockout_active_next;

  logic [bdl_pkg::IDX_W-1:0] pressed;
  logic [bdl_pkg::IDX_W-1:0] chord;
  logic [bdl_pkg::IDX_W-1:0] fresh;
  logic                      held_pin_high;
  logic [bdl_pkg::CNT_W-1:0] count_sat;

  always_comb begin
    pressed       = '0;
    held_pin_high = 1'b0;
    for (int i = 0; i < bdl_pkg::BUTTON_COUNT; i++) begin
      if (registered_index != bdl_pkg::IDX_W'(i + 1) && !levels[i])
        pressed = bdl_pkg::IDX_W'(i + 1);
      if (registered_index == bdl_pkg::IDX_W'(i + 1))
        held_pin_high = levels[i];
    end
  end

  assign count_sat = (tick_count == bdl_pkg::CNT_MAX) ? tick_count
                                                       : tick_count + bdl_pkg::CNT_W'(1);

  always_comb begin
    registered_index_next = registered_index;
    tick_count_next       = tick_count;
    lockout_active_next   = lockout_active;
    chord                 = '0;
    fresh                 = '0;
    if (!lockout_active) begin
      if (registered_index == bdl_pkg::IDX_W'(bdl_pkg::BUTTON_COUNT) && pressed != '0 &&
          pressed < bdl_pkg::IDX_W'(bdl_pkg::BUTTON_COUNT) && game_active)
        chord = pressed;
      if (registered_index == '0) begin
        if (pressed != '0) begin
          registered_index_next = pressed;
          tick_count_next       = '0;
          fresh                 = pressed;
        end
      end else begin
        tick_count_next = count_sat;
        if (count_sat >= cfg.debounce_ticks && held_pin_high) begin
          registered_index_next = '0;
          tick_count_next       = '0;
          lockout_active_next   = 1'b1;
        end
      end
    end else begin
      tick_count_next = count_sat;
      if (count_sat >= cfg.lockout_ticks) begin
        lockout_active_next = 1'b0;
        tick_count_next     = '0;
      end
    end
  end

  always_comb begin
    res.new_press    = bdl_pkg::FIELD_W'(fresh);
    res.chord_button = bdl_pkg::FIELD_W'(chord);
    res.held_button  = bdl_pkg::FIELD_W'(registered_index_next);
    res.busy         = (registered_index_next != '0) || lockout_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered_index <= '0;
      tick_count       <= '0;
      lockout_active   <= 1'b0;
    end else if (advance) begin
      registered_index <= registered_index_next;
      tick_count       <= tick_count_next;
      lockout_active   <= lockout_active_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_debounce_lockout_top.sv =====
// An accepted input beat is held in the input register, then its result in the
// result register on out_valid. Throughput: one tick beat per cycle while result
// beats are taken; each beat feeds one state update and the result register.
// The input register stalls only while it is full and the result beat is not taken.
// Reset (rst, synchronous): no button registered, counter and lockout clear,
// both tick registers return to 60, both stages empty.
`default_nettype none

module button_debounce_lockout_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [bdl_pkg::BUTTON_COUNT-1:0]   button_levels,
  input  wire                               game_active,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [bdl_pkg::FIELD_W-1:0]       new_press,
  output logic [bdl_pkg::FIELD_W-1:0]       chord_button,
  output logic [bdl_pkg::FIELD_W-1:0]       held_button,
  output logic                              busy_res,
  input  wire                               cfg_we,
  input  wire                               cfg_index,
  input  wire [bdl_pkg::CFG_W-1:0]          cfg_data
);

  logic                             in_full;
  logic [bdl_pkg::BUTTON_COUNT-1:0] levels_q;
  logic                             active_q;
  logic                             advance;
  bdl_pkg::cfg_t                    cfg;
  bdl_pkg::res_t                    res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  bdl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .levels      (levels_q),
    .game_active (active_q),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      levels_q <= button_levels;
      active_q <= game_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_press    <= res.new_press;
      chord_button <= res.chord_button;
      held_button  <= res.held_button;
      busy_res     <= res.busy;
    end
  end

`ifndef SYNTHESIS
  a_press_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_press != '0 |-> held_button == new_press)
    else $error("new press not shown as held");

  a_chord_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && chord_button != '0 |->
      new_press == '0 && chord_button < bdl_pkg::FIELD_W'(bdl_pkg::BUTTON_COUNT))
    else $error("chord on a fresh press or on the command button");

  a_held_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && held_button != '0 |-> busy_res)
    else $error("held button without busy");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
